// ----- design/krt_pkg.sv -----
// keyed record table: shared types, action codes and sizing constants
// no dependencies

package krt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int USED_W      = 5;

    localparam logic [7:0] MAX_GRADE_RST = 8'd100;

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_DEL    = 3'd1;
    localparam logic [2:0] ACT_READ   = 3'd2;
    localparam logic [2:0] ACT_EXISTS = 3'd3;
    localparam logic [2:0] ACT_LIST   = 3'd4;

    typedef struct packed {
        logic [7:0] key;
        logic [7:0] year;
        logic [7:0] course1;
        logic [7:0] grade1;
        logic [7:0] course2;
        logic [7:0] grade2;
        logic [7:0] course3;
        logic [7:0] grade3;
    } t_rec;

    typedef struct packed {
        logic             rotate;
        logic             shift;
        logic [IDX_W-1:0] shift_idx;
        logic             write;
        logic [IDX_W-1:0] wr_idx;
    } t_cell_ctl;

endpackage

// ----- design/keyed_record_table.sv -----
// add, unknown actions and list of an empty table go from acceptance through S_DONE to the
// output register; delete, read and exists first walk one full ring rotation in S_WALK
// list issues one key per cycle while the output is not stalled, over one full ring rotation
// one transaction in flight: a new action is accepted only once the last result is loaded
// reset: record count cleared, max grade set to 100, record contents left undefined
// top level: controller plus the ring of record cells; depends on krt_pkg, krt_cell, krt_ctrl

module keyed_record_table
    import krt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_max_grade,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_action,
    input  logic [7:0]        i_key_id,
    input  logic [7:0]        i_new_year,
    input  logic [7:0]        i_new_course1,
    input  logic [7:0]        i_new_grade1,
    input  logic [7:0]        i_new_course2,
    input  logic [7:0]        i_new_grade2,
    input  logic [7:0]        i_new_course3,
    input  logic [7:0]        i_new_grade3,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_ok,
    output logic [7:0]        o_out_id,
    output logic [7:0]        o_out_year,
    output logic [7:0]        o_out_course1,
    output logic [7:0]        o_out_grade1,
    output logic [7:0]        o_out_course2,
    output logic [7:0]        o_out_grade2,
    output logic [7:0]        o_out_course3,
    output logic [7:0]        o_out_grade3,
    output logic [USED_W-1:0] o_used_count,
    output logic              o_full_res,
    output logic              o_last
);

    t_cell_ctl w_ctl;
    t_rec      w_wdata;
    t_rec      w_rec [TABLE_DEPTH];

    krt_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_max_grade (i_cfg_max_grade),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_key_id        (i_key_id),
        .i_new_year      (i_new_year),
        .i_new_course1   (i_new_course1),
        .i_new_grade1    (i_new_grade1),
        .i_new_course2   (i_new_course2),
        .i_new_grade2    (i_new_grade2),
        .i_new_course3   (i_new_course3),
        .i_new_grade3    (i_new_grade3),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_ok            (o_ok),
        .o_out_id        (o_out_id),
        .o_out_year      (o_out_year),
        .o_out_course1   (o_out_course1),
        .o_out_grade1    (o_out_grade1),
        .o_out_course2   (o_out_course2),
        .o_out_grade2    (o_out_grade2),
        .o_out_course3   (o_out_course3),
        .o_out_grade3    (o_out_grade3),
        .o_used_count    (o_used_count),
        .o_full_res      (o_full_res),
        .o_last          (o_last),
        .i_head          (w_rec[0]),
        .o_ctl           (w_ctl),
        .o_wdata         (w_wdata)
    );

    // ring of cells, each fed by its upper neighbour, the top one wrapping to the head
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        krt_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_wdata (w_wdata),
            .i_next  (w_rec[(g + 1) % TABLE_DEPTH]),
            .o_rec   (w_rec[g])
        );
    end

endmodule

// ----- design/krt_cell.sv -----
// one record slot of the table chain: ring rotation, compaction and append
// depends on krt_pkg

module krt_cell
    import krt_pkg::*;
(
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cell_ctl        i_ctl,
    input  t_rec             i_wdata,
    input  t_rec             i_next,
    output t_rec             o_rec
);

    t_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (i_ctl.write && (i_idx == i_ctl.wr_idx)) begin
            r_rec <= i_wdata;
        end else if (i_ctl.rotate || (i_ctl.shift && (i_idx >= i_ctl.shift_idx))) begin
            r_rec <= i_next;
        end
    end

    assign o_rec = r_rec;

endmodule

// ----- design/krt_ctrl.sv -----
// sequencer for the record chain: walks the ring, tracks the count, builds results
// depends on krt_pkg

module krt_ctrl
    import krt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_max_grade,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_action,
    input  logic [7:0]        i_key_id,
    input  logic [7:0]        i_new_year,
    input  logic [7:0]        i_new_course1,
    input  logic [7:0]        i_new_grade1,
    input  logic [7:0]        i_new_course2,
    input  logic [7:0]        i_new_grade2,
    input  logic [7:0]        i_new_course3,
    input  logic [7:0]        i_new_grade3,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_ok,
    output logic [7:0]        o_out_id,
    output logic [7:0]        o_out_year,
    output logic [7:0]        o_out_course1,
    output logic [7:0]        o_out_grade1,
    output logic [7:0]        o_out_course2,
    output logic [7:0]        o_out_grade2,
    output logic [7:0]        o_out_course3,
    output logic [7:0]        o_out_grade3,
    output logic [USED_W-1:0] o_used_count,
    output logic              o_full_res,
    output logic              o_last,
    input  t_rec              i_head,
    output t_cell_ctl         o_ctl,
    output t_rec              o_wdata
);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [7:0]        r_max_grade;
    logic [2:0]        r_act;
    logic [7:0]        r_key;
    logic [IDX_W-1:0]  r_step;
    logic [IDX_W-1:0]  r_hit;
    logic              r_found;
    t_rec              r_rec;
    logic              r_out_valid;
    logic              r_out_ok;
    t_rec              r_out_rec;
    logic [USED_W-1:0] r_out_used;
    logic              r_out_full;
    logic              r_out_last;

    logic             out_free;
    logic [CNT_W-1:0] step_ext;
    logic             in_range;
    logic             head_hit;
    logic             list_emit;
    logic             walk_adv;
    logic             step_last;
    logic             in_fire;
    logic             add_good;
    logic             del_hit;
    logic [CNT_W-1:0] n_count;
    logic             out_load;

    always_comb begin
        out_free  = !r_out_valid || i_out_ready;
        step_ext  = CNT_W'(r_step);
        in_range  = step_ext < r_count;
        head_hit  = in_range && (i_head.key == r_key);
        list_emit = (r_act == ACT_LIST) && in_range;
        walk_adv  = (r_state == S_WALK) && (!list_emit || out_free);
        step_last = r_step == IDX_W'(TABLE_DEPTH - 1);
        in_fire   = i_in_valid && (r_state == S_IDLE);
        add_good  = (r_count < CNT_W'(TABLE_DEPTH)) &&
                    (i_new_grade1 <= r_max_grade) &&
                    (i_new_grade2 <= r_max_grade) &&
                    (i_new_grade3 <= r_max_grade);
        del_hit   = (r_act == ACT_DEL) && r_found;
        n_count   = del_hit ? (r_count - CNT_W'(1)) : r_count;
        out_load  = (walk_adv && list_emit) || ((r_state == S_DONE) && out_free);

        o_ctl.rotate    = walk_adv;
        o_ctl.shift     = (r_state == S_DONE) && out_free && del_hit;
        o_ctl.shift_idx = r_hit;
        o_ctl.write     = in_fire && (i_action == ACT_ADD) && add_good;
        o_ctl.wr_idx    = r_count[IDX_W-1:0];

        o_wdata.key     = i_key_id;
        o_wdata.year    = i_new_year;
        o_wdata.course1 = i_new_course1;
        o_wdata.grade1  = i_new_grade1;
        o_wdata.course2 = i_new_course2;
        o_wdata.grade2  = i_new_grade2;
        o_wdata.course3 = i_new_course3;
        o_wdata.grade3  = i_new_grade3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_max_grade <= MAX_GRADE_RST;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_grade <= i_cfg_max_grade;
            end
            if (r_out_valid && i_out_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act   <= i_action;
                        r_key   <= i_key_id;
                        r_step  <= '0;
                        r_found <= (i_action == ACT_ADD) && add_good;
                        case (i_action)
                            ACT_ADD: begin
                                if (add_good) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                                r_state <= S_DONE;
                            end
                            ACT_DEL, ACT_READ, ACT_EXISTS: begin
                                r_state <= S_WALK;
                            end
                            ACT_LIST: begin
                                r_state <= (r_count == '0) ? S_DONE : S_WALK;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (walk_adv) begin
                        r_step <= r_step + IDX_W'(1);
                        if (head_hit && !r_found && (r_act != ACT_LIST)) begin
                            r_found <= 1'b1;
                            r_hit   <= r_step;
                            r_rec   <= i_head;
                        end
                        if (list_emit) begin
                            r_out_valid   <= 1'b1;
                            r_out_ok      <= 1'b1;
                            r_out_rec     <= {i_head.key, 56'd0};
                            r_out_used    <= USED_W'(r_count);
                            r_out_full    <= r_count == CNT_W'(TABLE_DEPTH);
                            r_out_last    <= (step_ext + CNT_W'(1)) == r_count;
                        end
                        if (step_last) begin
                            r_state <= (r_act == ACT_LIST) ? S_IDLE : S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                        r_out_ok    <= r_found;
                        r_out_rec   <= ((r_act == ACT_READ) && r_found) ? r_rec : '0;
                        r_out_used  <= USED_W'(n_count);
                        r_out_full  <= n_count == CNT_W'(TABLE_DEPTH);
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = r_state == S_IDLE;
    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_out_ok;
    assign o_out_id      = r_out_rec.key;
    assign o_out_year    = r_out_rec.year;
    assign o_out_course1 = r_out_rec.course1;
    assign o_out_grade1  = r_out_rec.grade1;
    assign o_out_course2 = r_out_rec.course2;
    assign o_out_grade2  = r_out_rec.grade2;
    assign o_out_course3 = r_out_rec.course3;
    assign o_out_grade3  = r_out_rec.grade3;
    assign o_used_count  = r_out_used;
    assign o_full_res    = r_out_full;
    assign o_last        = r_out_last;

    // count stays within capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("record count beyond capacity");

    // chain sees at most one operation per cycle
    a_ctl_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctl.rotate, o_ctl.shift, o_ctl.write}))
        else $error("conflicting chain operations");

    // walk pointer steps by one on every rotation
    a_step_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (walk_adv && !step_last) |=> (r_step == IDX_W'($past(r_step) + IDX_W'(1))))
        else $error("walk pointer skipped");

    // count moves only by one entry per transaction
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CNT_W'(1)) ||
             (r_count == $past(r_count) - CNT_W'(1))))
        else $error("count jumped");

    // a compaction happens only when a delete found its key
    a_shift_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.shift |-> (r_found && (r_act == ACT_DEL) && (r_count != '0)))
        else $error("compaction without a match");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// testbench for keyed_record_table: directed table then random traffic, results checked against
// an in-bench model of the record table, typed rows against their own ok and used; depends on krt_pkg

module testbench;
    import krt_pkg::*;

    localparam logic [2:0] ACT_RSVD_5 = 3'd5;
    localparam logic [2:0] ACT_RSVD_6 = 3'd6;
    localparam logic [2:0] ACT_RSVD_7 = 3'd7;

    localparam int NUM_ROWS        = 24;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 56;
    localparam int HOLD_PHASE      = 2;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 2 * TABLE_DEPTH + 8;
    localparam int STALL_LIMIT     = 4000;

    typedef struct packed {
        logic [2:0] act;
        t_rec       rec;
    } t_cmd;

    typedef struct packed {
        logic              ok;
        t_rec              rec;
        logic [USED_W-1:0] used;
        logic              full;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [2:0]        act;
        logic [7:0]        key;
        logic [7:0]        year;
        logic [7:0]        course;
        logic [7:0]        g1;
        logic [7:0]        g2;
        logic [7:0]        g3;
        logic [4:0]        reps;
        logic              typed;
        logic              t_ok;
        logic [USED_W-1:0] t_used;
    } t_row;

    // act, key, year, course, grades, repeats, typed, ok, used
    t_row dir_rows [NUM_ROWS] = '{
        '{ACT_LIST,   8'h00, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b1, 1'b0, 5'd0},
        '{ACT_READ,   8'h00, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b1, 1'b0, 5'd0},
        '{ACT_DEL,    8'hff, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b1, 1'b0, 5'd0},
        '{ACT_EXISTS, 8'h00, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b1, 1'b0, 5'd0},
        '{ACT_RSVD_5, 8'haa, 8'h55, 8'hff, 8'hff,  8'hff,  8'hff,  5'd1,  1'b1, 1'b0, 5'd0},
        '{ACT_RSVD_6, 8'h55, 8'haa, 8'h00, 8'h00,  8'h00,  8'h00,  5'd1,  1'b1, 1'b0, 5'd0},
        '{ACT_RSVD_7, 8'hff, 8'hff, 8'hff, 8'h7f,  8'h80,  8'h01,  5'd1,  1'b1, 1'b0, 5'd0},
        '{ACT_ADD,    8'h00, 8'hff, 8'h00, 8'd100, 8'd100, 8'd100, 5'd1,  1'b1, 1'b1, 5'd1},
        '{ACT_ADD,    8'hff, 8'h00, 8'hff, 8'd101, 8'd0,   8'd0,   5'd1,  1'b1, 1'b0, 5'd1},
        '{ACT_ADD,    8'hff, 8'h00, 8'hff, 8'd0,   8'd0,   8'd255, 5'd1,  1'b1, 1'b0, 5'd1},
        '{ACT_ADD,    8'hff, 8'h00, 8'hff, 8'd0,   8'd0,   8'd0,   5'd1,  1'b1, 1'b1, 5'd2},
        '{ACT_ADD,    8'h00, 8'h12, 8'h34, 8'd7,   8'd8,   8'd9,   5'd1,  1'b1, 1'b1, 5'd3},
        '{ACT_READ,   8'h00, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b0, 1'b0, 5'd0},
        '{ACT_EXISTS, 8'hff, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b1, 1'b1, 5'd3},
        '{ACT_LIST,   8'h00, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b0, 1'b0, 5'd0},
        '{ACT_DEL,    8'h00, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b1, 1'b1, 5'd2},
        '{ACT_READ,   8'h00, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b0, 1'b0, 5'd0},
        '{ACT_ADD,    8'h10, 8'h40, 8'h21, 8'd50,  8'd60,  8'd70,  5'd14, 1'b0, 1'b0, 5'd0},
        '{ACT_ADD,    8'h80, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b1, 1'b0, 5'd16},
        '{ACT_LIST,   8'h00, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b0, 1'b0, 5'd0},
        '{ACT_READ,   8'h15, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b0, 1'b0, 5'd0},
        '{ACT_DEL,    8'h10, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b1, 1'b1, 5'd15},
        '{ACT_DEL,    8'h1d, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b1, 1'b1, 5'd14},
        '{ACT_EXISTS, 8'h10, 8'h00, 8'h00, 8'd0,   8'd0,   8'd0,   5'd1,  1'b1, 1'b0, 5'd14}
    };

    logic [7:0] phase_caps [NUM_PHASES] = '{8'd255, 8'd0, 8'd100, 8'd1, 8'd254, 8'd128, 8'd37};
    int         phase_adds [NUM_PHASES] = '{60, 35, 60, 30, 55, 40, 50};

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_valid     = 1'b0;
    logic [7:0]        cfg_max_grade = '0;
    logic              in_valid      = 1'b0;
    logic [2:0]        in_action     = '0;
    t_rec              in_rec        = '0;
    logic              out_ready     = 1'b0;
    logic              hold_go       = 1'b0;

    logic              o_cfg_ready;
    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_ok;
    logic [7:0]        o_out_id;
    logic [7:0]        o_out_year;
    logic [7:0]        o_out_course1;
    logic [7:0]        o_out_grade1;
    logic [7:0]        o_out_course2;
    logic [7:0]        o_out_grade2;
    logic [7:0]        o_out_course3;
    logic [7:0]        o_out_grade3;
    logic [USED_W-1:0] o_used_count;
    logic              o_full_res;
    logic              o_last;

    t_rec       tbl [TABLE_DEPTH];
    int         tbl_count = 0;
    logic [7:0] grade_cap = MAX_GRADE_RST;

    t_result    step_results [$];
    t_result    pending_results [$];
    int         mismatches  = 0;
    int         burst_left  = 0;
    int         idle_cycles = 0;

    keyed_record_table dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_max_grade (cfg_max_grade),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (in_action),
        .i_key_id        (in_rec.key),
        .i_new_year      (in_rec.year),
        .i_new_course1   (in_rec.course1),
        .i_new_grade1    (in_rec.grade1),
        .i_new_course2   (in_rec.course2),
        .i_new_grade2    (in_rec.grade2),
        .i_new_course3   (in_rec.course3),
        .i_new_grade3    (in_rec.grade3),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_ok            (o_ok),
        .o_out_id        (o_out_id),
        .o_out_year      (o_out_year),
        .o_out_course1   (o_out_course1),
        .o_out_grade1    (o_out_grade1),
        .o_out_course2   (o_out_course2),
        .o_out_grade2    (o_out_grade2),
        .o_out_course3   (o_out_course3),
        .o_out_grade3    (o_out_grade3),
        .o_used_count    (o_used_count),
        .o_full_res      (o_full_res),
        .o_last          (o_last)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic t_result stamp_count(input t_result r, input int count, input bit last);
        t_result s;
        s      = r;
        s.used = count[USED_W-1:0];
        s.full = (count == TABLE_DEPTH);
        s.last = last;
        return s;
    endfunction

    function automatic void table_step(input t_cmd c);
        t_result r;
        int      hit;
        bit      good;
        step_results.delete();
        r   = '0;
        hit = -1;
        for (int i = tbl_count - 1; i >= 0; i--) begin
            if (tbl[i].key == c.rec.key) hit = i;
        end
        case (c.act)
            ACT_LIST: begin
                for (int i = 0; i < tbl_count; i++) begin
                    r        = '0;
                    r.ok     = 1'b1;
                    r.rec.key = tbl[i].key;
                    step_results.push_back(stamp_count(r, tbl_count, i == tbl_count - 1));
                end
                r = '0;
            end
            ACT_ADD: begin
                good = (tbl_count < TABLE_DEPTH) && (c.rec.grade1 <= grade_cap)
                    && (c.rec.grade2 <= grade_cap) && (c.rec.grade3 <= grade_cap);
                if (good) begin
                    tbl[tbl_count] = c.rec;
                    tbl_count++;
                    r.ok = 1'b1;
                end
            end
            ACT_DEL: begin
                if (hit >= 0) begin
                    for (int i = hit; i < tbl_count - 1; i++) tbl[i] = tbl[i + 1];
                    tbl_count--;
                    r.ok = 1'b1;
                end
            end
            ACT_READ: begin
                if (hit >= 0) begin
                    r.ok  = 1'b1;
                    r.rec = tbl[hit];
                end
            end
            ACT_EXISTS: r.ok = (hit >= 0);
            default: ;
        endcase
        if (c.act != ACT_LIST || tbl_count == 0)
            step_results.push_back(stamp_count(r, tbl_count, 1'b1));
    endfunction

    function automatic logic [7:0] random_grade();
        if ($urandom_range(0, 9) < 8) return 8'($urandom_range(0, grade_cap));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_cmd random_cmd(input int add_pct);
        t_cmd c;
        int   roll;
        if ($urandom_range(0, 99) < add_pct) begin
            c.act = ACT_ADD;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 30)      c.act = ACT_DEL;
            else if (roll < 55) c.act = ACT_READ;
            else if (roll < 75) c.act = ACT_EXISTS;
            else if (roll < 88) c.act = ACT_LIST;
            else                c.act = 3'($urandom_range(ACT_RSVD_5, ACT_RSVD_7));
        end
        if (tbl_count != 0 && $urandom_range(0, 1) == 1)
            c.rec.key = tbl[$urandom_range(0, tbl_count - 1)].key;
        else if ($urandom_range(0, 2) != 0)
            c.rec.key = 8'($urandom_range(0, 15));
        else
            c.rec.key = 8'($urandom);
        c.rec.year    = 8'($urandom);
        c.rec.course1 = 8'($urandom);
        c.rec.course2 = 8'($urandom);
        c.rec.course3 = 8'($urandom);
        c.rec.grade1  = random_grade();
        c.rec.grade2  = random_grade();
        c.rec.grade3  = random_grade();
        return c;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0
                : $urandom_range(1, ($urandom_range(0, 4) == 0) ? 30 : 5);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic put_item(input t_cmd c, input bit typed, input t_result typed_res);
        in_valid  <= 1'b1;
        in_action <= c.act;
        in_rec    <= c.rec;
        do @(posedge clk); while (!o_in_ready);
        table_step(c);
        if (typed) pending_results.push_back(typed_res);
        else foreach (step_results[i]) pending_results.push_back(step_results[i]);
    endtask

    task automatic write_max_grade(input logic [7:0] v);
        cfg_valid     <= 1'b1;
        cfg_max_grade <= v;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        grade_cap  = v;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // receiver: stall rate redrawn at random, plus one long hold-off
    always @(posedge clk) begin
        static int rx_cycles = 0;
        static int stall_pct = 0;
        static int hold_left = 0;
        static bit hold_done = 1'b0;
        rx_cycles++;
        if (rx_cycles % 64 == 0) begin
            case ($urandom_range(0, 3))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 30;
                default: stall_pct = 70;
            endcase
        end
        if (hold_go && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        t_result want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: out_id %0h", o_out_id);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("ok", want.ok, o_ok);
                check_field("out_id", want.rec.key, o_out_id);
                check_field("out_year", want.rec.year, o_out_year);
                check_field("out_course1", want.rec.course1, o_out_course1);
                check_field("out_grade1", want.rec.grade1, o_out_grade1);
                check_field("out_course2", want.rec.course2, o_out_course2);
                check_field("out_grade2", want.rec.grade2, o_out_grade2);
                check_field("out_course3", want.rec.course3, o_out_course3);
                check_field("out_grade3", want.rec.grade3, o_out_grade3);
                check_field("used_count", want.used, o_used_count);
                check_field("full_res", want.full, o_full_res);
                check_field("last", want.last, o_last);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || (cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_row    row;
        t_cmd    c;
        t_result typed_res;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            for (int n = 0; n < row.reps; n++) begin
                c.act     = row.act;
                c.rec     = '{8'(row.key + n), 8'(row.year + n), row.course, row.g1,
                              ~row.course, row.g2, row.course ^ 8'h5a, row.g3};
                typed_res    = stamp_count('0, row.t_used, 1'b1);
                typed_res.ok = row.t_ok;
                pace_sender();
                put_item(c, row.typed, typed_res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_max_grade(phase_caps[p]);
            if (p == HOLD_PHASE) hold_go <= 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pace_sender();
                put_item(random_cmd(phase_adds[p]), 1'b0, '0);
            end
        end
        drain();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
